FILE: rtl/rshg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the rainbow strip HSV generator.
// No dependencies; every other file imports this package.
package rshg_pkg;

    localparam int STRIP_LENGTH_DEF = 32;

    localparam int IDX_W  = 6;
    localparam int HUE_W  = 9;
    localparam int CH_W   = 8;
    localparam int CFG_AW = 1;

    localparam logic [HUE_W-1:0] HUE_FULL   = 9'd360;
    localparam logic [HUE_W-1:0] HUE_SECTOR = 9'd60;
    localparam logic [CH_W-1:0]  CH_MAX     = 8'd255;

    localparam logic [CFG_AW-1:0] REG_SATURATION = 1'b0;
    localparam logic [CFG_AW-1:0] REG_BRIGHTNESS = 1'b1;

    // Frame request as seen by the pixel sequencer: offset already below 360.
    typedef struct packed {
        logic             valid;
        logic [HUE_W-1:0] offset;
    } t_frame;

    // One pixel on its way into the color conversion pipeline.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
        logic [HUE_W-1:0] hue;
    } t_pix;

endpackage

FILE: rtl/rshg_front.sv
`timescale 1ns / 1ps
// Input side: takes frame requests, reduces the offset below 360 and
// holds up to two pending requests. Depends on rshg_pkg.
module rshg_front
    import rshg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tvalid,
    output logic             o_tready,
    input  logic [HUE_W-1:0] i_offset,
    input  logic             i_pop,
    output t_frame           o_frame
);

    logic [HUE_W-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             push;
    logic [HUE_W-1:0] offset_red;

    assign o_tready   = (r_count != 2'd2);
    assign push       = i_tvalid && o_tready;
    assign offset_red = (i_offset >= HUE_FULL) ? (i_offset - HUE_FULL) : i_offset;

    assign o_frame.valid  = (r_count != 2'd0);
    assign o_frame.offset = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= offset_red;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count != 2'd3)
        else $error("Request queue count out of range.");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> r_count != 2'd0)
        else $error("Request queue popped while empty.");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd0 |-> r_mem[r_rd_ptr] < HUE_FULL)
        else $error("Stored offset not reduced.");

endmodule

FILE: rtl/rshg_seq.sv
`timescale 1ns / 1ps
// Pixel sequencer: walks the strip for each frame request, tracking the base
// hue incrementally as quotient and remainder. Depends on rshg_pkg.
module rshg_seq
    import rshg_pkg::*;
#(
    parameter int STRIP_LENGTH = STRIP_LENGTH_DEF
)(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  t_frame i_frame,
    output logic   o_pop,
    output logic   o_pix_valid,
    output t_pix   o_pix
);

    localparam logic [HUE_W-1:0] STEP_Q   = HUE_W'(360 / STRIP_LENGTH);
    localparam logic [6:0]       STEP_R   = 7'(360 % STRIP_LENGTH);
    localparam logic [6:0]       LEN      = 7'(STRIP_LENGTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STRIP_LENGTH - 1);

    logic             r_active;
    logic [IDX_W-1:0] r_idx;
    logic [HUE_W-1:0] r_base_q;
    logic [6:0]       r_base_r;
    logic [HUE_W-1:0] r_off;
    logic             r_pix_valid;
    t_pix             r_pix;

    logic             is_last;
    logic             reload;
    logic [HUE_W:0]   hue_sum;
    logic [HUE_W-1:0] hue;
    logic [6:0]       rem_sum;

    assign is_last = (r_idx == LAST_IDX);
    assign reload  = !r_active || is_last;
    assign o_pop   = i_adv && reload && i_frame.valid;

    assign hue_sum = {1'b0, r_base_q} + {1'b0, r_off};
    assign hue     = (hue_sum >= {1'b0, HUE_FULL}) ? HUE_W'(hue_sum - {1'b0, HUE_FULL})
                                                   : hue_sum[HUE_W-1:0];
    assign rem_sum = r_base_r + STEP_R;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_pix_valid <= 1'b0;
            r_idx       <= '0;
            r_base_q    <= '0;
            r_base_r    <= '0;
            r_off       <= '0;
        end else if (i_adv) begin
            r_pix_valid <= r_active;
            r_pix.idx   <= r_idx;
            r_pix.last  <= is_last;
            r_pix.hue   <= hue;
            if (reload) begin
                r_active <= i_frame.valid;
                r_idx    <= '0;
                r_base_q <= '0;
                r_base_r <= '0;
                r_off    <= i_frame.offset;
            end else begin
                r_idx <= r_idx + 1'b1;
                if (rem_sum >= LEN) begin
                    r_base_r <= rem_sum - LEN;
                    r_base_q <= r_base_q + STEP_Q + 1'b1;
                end else begin
                    r_base_r <= rem_sum;
                    r_base_q <= r_base_q + STEP_Q;
                end
            end
        end
    end

    assign o_pix_valid = r_pix_valid;
    assign o_pix       = r_pix;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix_valid && r_pix.last |-> r_pix.idx == LAST_IDX)
        else $error("Last pixel flag on wrong index.");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix_valid |-> r_pix.hue < HUE_FULL)
        else $error("Pixel hue out of range.");

endmodule

FILE: rtl/rshg_hsv.sv
`timescale 1ns / 1ps
// Five-stage HSV to RGB pipeline with the output register as its last stage.
// Divisions by 60 and 255 use exact reciprocal forms. Depends on rshg_pkg.
module rshg_hsv
    import rshg_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pix_valid,
    input  t_pix            i_pix,
    input  logic [CH_W-1:0] i_sat,
    input  logic [CH_W-1:0] i_val,
    output logic            o_adv,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [IDX_W-1:0] o_idx,
    output logic [CH_W-1:0] o_red,
    output logic [CH_W-1:0] o_green,
    output logic [CH_W-1:0] o_blue,
    output logic            o_last
);

    typedef enum logic [2:0] {
        SEC_RED_YEL, SEC_YEL_GRN, SEC_GRN_CYN, SEC_CYN_BLU, SEC_BLU_MAG, SEC_MAG_RED
    } t_sector;

    localparam logic [14:0] RECIP60 = 15'd17477;

    function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    logic             r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic [IDX_W-1:0] r_idx1, r_idx2, r_idx3, r_idx4, r_out_idx;
    logic             r_last1, r_last2, r_last3, r_last4, r_out_last;
    t_sector          r_sec1, r_sec2, r_sec3, r_sec4;
    logic [5:0]       r_rem1;
    logic [13:0]      r_sr2, r_st2;
    logic [15:0]      r_pv2;
    logic [CH_W-1:0]  r_qa3, r_qb3, r_p3, r_p4;
    logic [15:0]      r_mq4, r_mt4;
    logic [CH_W-1:0]  r_red, r_green, r_blue;

    t_sector          sec;
    logic [HUE_W-1:0] sec_base;
    logic [28:0]      prod_a, prod_b;
    logic [CH_W-1:0]  q5, t5, p5;
    logic [CH_W-1:0]  red, green, blue;

    assign o_adv = !r_out_valid || i_tready;

    always_comb begin
        if (i_pix.hue >= HUE_W'(5 * HUE_SECTOR)) begin
            sec = SEC_MAG_RED; sec_base = HUE_W'(5 * HUE_SECTOR);
        end else if (i_pix.hue >= HUE_W'(4 * HUE_SECTOR)) begin
            sec = SEC_BLU_MAG; sec_base = HUE_W'(4 * HUE_SECTOR);
        end else if (i_pix.hue >= HUE_W'(3 * HUE_SECTOR)) begin
            sec = SEC_CYN_BLU; sec_base = HUE_W'(3 * HUE_SECTOR);
        end else if (i_pix.hue >= HUE_W'(2 * HUE_SECTOR)) begin
            sec = SEC_GRN_CYN; sec_base = HUE_W'(2 * HUE_SECTOR);
        end else if (i_pix.hue >= HUE_SECTOR) begin
            sec = SEC_YEL_GRN; sec_base = HUE_SECTOR;
        end else begin
            sec = SEC_RED_YEL; sec_base = '0;
        end
    end

    assign prod_a = 29'(r_sr2) * 29'(RECIP60);
    assign prod_b = 29'(r_st2) * 29'(RECIP60);

    assign q5 = div255(r_mq4);
    assign t5 = div255(r_mt4);
    assign p5 = r_p4;

    always_comb begin
        unique case (r_sec4)
            SEC_RED_YEL: begin red = i_val; green = t5;    blue = p5;    end
            SEC_YEL_GRN: begin red = q5;    green = i_val; blue = p5;    end
            SEC_GRN_CYN: begin red = p5;    green = i_val; blue = t5;    end
            SEC_CYN_BLU: begin red = p5;    green = q5;    blue = i_val; end
            SEC_BLU_MAG: begin red = t5;    green = p5;    blue = i_val; end
            default:     begin red = i_val; green = p5;    blue = q5;    end
        endcase
        if (i_sat == '0) begin
            red = i_val; green = i_val; blue = i_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_v1        <= i_pix_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_out_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_idx1  <= i_pix.idx;
            r_last1 <= i_pix.last;
            r_sec1  <= sec;
            r_rem1  <= 6'(i_pix.hue - sec_base);

            r_idx2  <= r_idx1;
            r_last2 <= r_last1;
            r_sec2  <= r_sec1;
            r_sr2   <= 14'(i_sat) * 14'(r_rem1);
            r_st2   <= 14'(i_sat) * 14'(6'(HUE_SECTOR) - r_rem1);
            r_pv2   <= 16'(i_val) * 16'(CH_MAX - i_sat);

            r_idx3  <= r_idx2;
            r_last3 <= r_last2;
            r_sec3  <= r_sec2;
            r_qa3   <= prod_a[27:20];
            r_qb3   <= prod_b[27:20];
            r_p3    <= div255(r_pv2);

            r_idx4  <= r_idx3;
            r_last4 <= r_last3;
            r_sec4  <= r_sec3;
            r_p4    <= r_p3;
            r_mq4   <= 16'(i_val) * 16'(CH_MAX - r_qa3);
            r_mt4   <= 16'(i_val) * 16'(CH_MAX - r_qb3);

            r_out_idx  <= r_idx4;
            r_out_last <= r_last4;
            r_red      <= red;
            r_green    <= green;
            r_blue     <= blue;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_idx    = r_out_idx;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;
    assign o_last   = r_out_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_rem1 < 6'(HUE_SECTOR))
        else $error("Sector remainder out of range.");

endmodule

FILE: rtl/rainbow_strip_hsv_generator.sv
`timescale 1ns / 1ps
// Top level of the rainbow strip HSV generator: configuration registers and
// the request queue, pixel sequencer and color pipeline. Depends on rshg_pkg.
//
// Each transfer on the slave side requests one frame with a hue offset in
// tdata[8:0]. The block answers with STRIP_LENGTH pixel transfers in index
// order, one per cycle while the master side is ready, the last one carrying
// tlast. The pixel sequencer issues one pixel per cycle while the pipeline
// advances, so frames follow each other with no gap. Up to two requests wait
// in a queue while a frame is being produced. Saturation (index 0) and
// brightness (index 1) reset to 255 and are written through the
// configuration port. The user must write them only while no frame is in
// flight; the block itself does not enforce this.
module rainbow_strip_hsv_generator
    import rshg_pkg::*;
#(
    parameter int STRIP_LENGTH = STRIP_LENGTH_DEF
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CH_W-1:0]   i_cfg_wdata,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [15:0]       i_s_axis_tdata,   // [8:0] hue_shift
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [31:0]       o_m_axis_tdata,   // [5:0] pixel_index, [13:6] red,
                                                // [21:14] green, [29:22] blue
    output logic              o_m_axis_tlast
);

    logic [CH_W-1:0]  r_sat;
    logic [CH_W-1:0]  r_bri;
    t_frame           frame;
    logic             pop;
    logic             adv;
    logic             pix_valid;
    t_pix             pix;
    logic [IDX_W-1:0] out_idx;
    logic [CH_W-1:0]  out_red, out_green, out_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= CH_MAX;
            r_bri <= CH_MAX;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_SATURATION) begin
                r_sat <= i_cfg_wdata;
            end
            if (i_cfg_addr == REG_BRIGHTNESS) begin
                r_bri <= i_cfg_wdata;
            end
        end
    end

    rshg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_offset (i_s_axis_tdata[HUE_W-1:0]),
        .i_pop    (pop),
        .o_frame  (frame)
    );

    rshg_seq #(
        .STRIP_LENGTH (STRIP_LENGTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_frame     (frame),
        .o_pop       (pop),
        .o_pix_valid (pix_valid),
        .o_pix       (pix)
    );

    rshg_hsv u_hsv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (pix_valid),
        .i_pix       (pix),
        .i_sat       (r_sat),
        .i_val       (r_bri),
        .o_adv       (adv),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_idx       (out_idx),
        .o_red       (out_red),
        .o_green     (out_green),
        .o_blue      (out_blue),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, out_blue, out_green, out_red, out_idx};

endmodule
